// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define QTE_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("check failed");

`define QTE_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");

`define QTE_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("check failed");

`endif

// ===== hdl/qte_pkg.sv =====
`timescale 1ns / 1ps
package qte_pkg;

   localparam int FRAC_BITS = 14;
   localparam logic [63:0] PI_Q30 = 64'd3373259426;

   localparam int HALF_TURN_DEG = 180;
   localparam int QUARTER_TURN_DEG = 90;
   localparam int OCTANT_DEG = 45;
   localparam int ASIN_HALF_DEG = 30;

   localparam int MAG_W = 33;
   localparam int SUM_W = 34;
   localparam int TAB_W = 32;
   localparam int TAB_HALF = TAB_W / 2;

   localparam int ATAN_STEPS = 6;
   localparam int ATAN_F_W = ATAN_STEPS;
   localparam int ATAN_LAT = 2 * ATAN_STEPS;
   localparam int ASIN_STEPS = 7;
   localparam int ASIN_F_W = ASIN_STEPS;
   localparam int FRONT_LAT = 3;
   localparam int TOTAL_LAT = FRONT_LAT + ATAN_LAT + 1;

   typedef logic [QUARTER_TURN_DEG:0][TAB_W-1:0] sin_tab_type;

   // sin(k deg) in Q30 by truncated Taylor series
   function automatic logic [TAB_W-1:0] sin_q30(int k);
      logic [63:0] a;
      logic [63:0] a2;
      logic [63:0] t;
      longint s;
      a = (64'(k) * PI_Q30 + 64'd90) / 64'd180;
      a2 = (a * a) >> 30;
      t = a;
      s = longint'(a);
      for (int n = 1; n <= 10; n++) begin
         t = ((t * a2) >> 30) / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            s = s - longint'(t);
         end else begin
            s = s + longint'(t);
         end
      end
      return (s < 0) ? '0 : TAB_W'(s);
   endfunction

   function automatic sin_tab_type sin_table();
      sin_tab_type tab;
      for (int k = 0; k <= QUARTER_TURN_DEG; k++) begin
         tab[k] = sin_q30(k);
      end
      return tab;
   endfunction

   localparam sin_tab_type SIN_TAB = sin_table();

   typedef struct packed {
      logic y_zero;
      logic x_zero;
      logic mag_eq;
      logic y_lt_x;
      logic x_neg;
      logic y_neg;
   } atan_side_type;

   typedef struct packed {
      logic [MAG_W-1:0] small_mag;
      logic [MAG_W-1:0] big_mag;
      atan_side_type side;
   } atan_in_type;

   typedef struct packed {
      logic [ATAN_F_W-1:0] f;
      atan_side_type side;
   } atan_out_type;

   typedef struct packed {
      logic [MAG_W-1:0] mag;
      logic neg;
   } asin_in_type;

   typedef struct packed {
      logic [ASIN_F_W-1:0] deg;
      logic sat;
      logic neg;
   } asin_out_type;

endpackage

// ===== hdl/qte_front.sv =====
`timescale 1ns / 1ps
module qte_front import qte_pkg::*; (
   input  logic              clock,
   input  logic signed [15:0] quat_x,
   input  logic signed [15:0] quat_y,
   input  logic signed [15:0] quat_z,
   input  logic signed [15:0] quat_w,
   output atan_in_type       pitch_in,
   output atan_in_type       roll_in,
   output asin_in_type       yaw_in
);

   logic signed [31:0] xx_ff, yy_ff, zz_ff, ww_ff;
   logic signed [31:0] yz_ff, wx_ff, xy_ff, wz_ff, wy_ff, xz_ff;
   logic signed [SUM_W-1:0] pnum_ff, pden_ff, rnum_ff, rden_ff, anum_ff;
   atan_in_type pitch_ff, roll_ff;
   asin_in_type yaw_ff;

   function automatic logic [MAG_W-1:0] mag_of(logic signed [SUM_W-1:0] v);
      return v[SUM_W-1] ? MAG_W'(-v) : MAG_W'(v);
   endfunction

   function automatic atan_in_type split(logic signed [SUM_W-1:0] num,
                                         logic signed [SUM_W-1:0] den);
      atan_in_type r;
      logic [MAG_W-1:0] ay;
      logic [MAG_W-1:0] ax;
      ay = mag_of(num);
      ax = mag_of(den);
      r.side.y_zero = (ay == '0);
      r.side.x_zero = (ax == '0);
      r.side.mag_eq = (ay == ax);
      r.side.y_lt_x = (ay < ax);
      r.side.x_neg = den[SUM_W-1];
      r.side.y_neg = num[SUM_W-1];
      r.small_mag = (ay < ax) ? ay : ax;
      r.big_mag = (ay < ax) ? ax : ay;
      return r;
   endfunction

   always_ff @(posedge clock) begin
      xx_ff <= quat_x * quat_x;
      yy_ff <= quat_y * quat_y;
      zz_ff <= quat_z * quat_z;
      ww_ff <= quat_w * quat_w;
      yz_ff <= quat_y * quat_z;
      wx_ff <= quat_w * quat_x;
      xy_ff <= quat_x * quat_y;
      wz_ff <= quat_w * quat_z;
      wy_ff <= quat_w * quat_y;
      xz_ff <= quat_x * quat_z;
   end

   always_ff @(posedge clock) begin
      pnum_ff <= (SUM_W'(yz_ff) + SUM_W'(wx_ff)) <<< 1;
      pden_ff <= SUM_W'(ww_ff) - SUM_W'(xx_ff) - SUM_W'(yy_ff) + SUM_W'(zz_ff);
      rnum_ff <= (SUM_W'(xy_ff) + SUM_W'(wz_ff)) <<< 1;
      rden_ff <= SUM_W'(ww_ff) + SUM_W'(xx_ff) - SUM_W'(yy_ff) - SUM_W'(zz_ff);
      anum_ff <= (SUM_W'(wy_ff) - SUM_W'(xz_ff)) <<< 1;
   end

   always_ff @(posedge clock) begin
      pitch_ff <= split(pnum_ff, pden_ff);
      roll_ff <= split(rnum_ff, rden_ff);
      yaw_ff.mag <= mag_of(anum_ff);
      yaw_ff.neg <= anum_ff[SUM_W-1];
   end

   assign pitch_in = pitch_ff;
   assign roll_in = roll_ff;
   assign yaw_in = yaw_ff;

endmodule

// ===== hdl/qte_atan.sv =====
`timescale 1ns / 1ps
module qte_atan import qte_pkg::*; (
   input  logic         clock,
   input  atan_in_type  atan_in,
   output atan_out_type atan_out
);

   localparam int PP_W = MAG_W + TAB_HALF;
   localparam int LHS_W = MAG_W + TAB_W;

   logic [MAG_W-1:0] small_w [0:ATAN_STEPS];
   logic [MAG_W-1:0] big_w [0:ATAN_STEPS];
   atan_side_type side_w [0:ATAN_STEPS];
   logic [ATAN_F_W-1:0] acc_w [0:ATAN_STEPS];

   assign small_w[0] = atan_in.small_mag;
   assign big_w[0] = atan_in.big_mag;
   assign side_w[0] = atan_in.side;
   assign acc_w[0] = '0;

   for (genvar gi = 0; gi < ATAN_STEPS; gi++) begin : g_step
      logic [ATAN_F_W-1:0] cand;
      logic cand_ok;
      logic [6:0] si;
      logic [6:0] ci;
      logic [TAB_W-1:0] sv;
      logic [TAB_W-1:0] cv;
      logic [PP_W-1:0] sc_hi_ff, sc_lo_ff, bs_hi_ff, bs_lo_ff;
      logic [ATAN_F_W-1:0] cand_ff, acc_a_ff, acc_b_ff;
      logic ok_ff;
      logic [MAG_W-1:0] small_a_ff, big_a_ff, small_b_ff, big_b_ff;
      atan_side_type side_a_ff, side_b_ff;
      logic [LHS_W-1:0] lhs;
      logic [LHS_W-1:0] rhs;
      logic [ATAN_F_W-1:0] acc_b_in;

      always_comb begin
         cand = acc_w[gi] | ATAN_F_W'(1 << (ATAN_STEPS - 1 - gi));
         cand_ok = (7'(cand) <= 7'(OCTANT_DEG - 1));
         si = cand_ok ? 7'(cand) : 7'd0;
         ci = 7'(QUARTER_TURN_DEG) - 7'(cand);
         sv = SIN_TAB[si];
         cv = SIN_TAB[ci];
      end

      always_ff @(posedge clock) begin
         sc_hi_ff <= PP_W'(small_w[gi]) * PP_W'(cv[TAB_W-1:TAB_HALF]);
         sc_lo_ff <= PP_W'(small_w[gi]) * PP_W'(cv[TAB_HALF-1:0]);
         bs_hi_ff <= PP_W'(big_w[gi]) * PP_W'(sv[TAB_W-1:TAB_HALF]);
         bs_lo_ff <= PP_W'(big_w[gi]) * PP_W'(sv[TAB_HALF-1:0]);
         cand_ff <= cand;
         ok_ff <= cand_ok;
         acc_a_ff <= acc_w[gi];
         small_a_ff <= small_w[gi];
         big_a_ff <= big_w[gi];
         side_a_ff <= side_w[gi];
      end

      always_comb begin
         lhs = (LHS_W'(sc_hi_ff) << TAB_HALF) + LHS_W'(sc_lo_ff);
         rhs = (LHS_W'(bs_hi_ff) << TAB_HALF) + LHS_W'(bs_lo_ff);
         acc_b_in = (ok_ff && (lhs >= rhs)) ? cand_ff : acc_a_ff;
      end

      always_ff @(posedge clock) begin
         acc_b_ff <= acc_b_in;
         small_b_ff <= small_a_ff;
         big_b_ff <= big_a_ff;
         side_b_ff <= side_a_ff;
      end

      assign acc_w[gi+1] = acc_b_ff;
      assign small_w[gi+1] = small_b_ff;
      assign big_w[gi+1] = big_b_ff;
      assign side_w[gi+1] = side_b_ff;
   end

   assign atan_out.f = acc_w[ATAN_STEPS];
   assign atan_out.side = side_w[ATAN_STEPS];

endmodule

// ===== hdl/qte_asin.sv =====
`timescale 1ns / 1ps
module qte_asin import qte_pkg::*; (
   input  logic         clock,
   input  asin_in_type  asin_in,
   output asin_out_type asin_out
);

   localparam int CMP_W = 64;
   localparam int SH_L = (2 * FRAC_BITS >= 30) ? 0 : 30 - 2 * FRAC_BITS;
   localparam int SH_R = (2 * FRAC_BITS >= 30) ? 2 * FRAC_BITS - 30 : 0;
   localparam logic [CMP_W-1:0] LIM = CMP_W'(1) << (2 * FRAC_BITS);
   localparam int PAD = ATAN_LAT - ASIN_STEPS;

   logic [MAG_W-1:0] mag_w [0:ASIN_STEPS];
   logic neg_w [0:ASIN_STEPS];
   logic [ASIN_F_W-1:0] acc_w [0:ASIN_STEPS];
   asin_out_type pad_w [0:PAD];

   assign mag_w[0] = asin_in.mag;
   assign neg_w[0] = asin_in.neg;
   assign acc_w[0] = '0;

   for (genvar gi = 0; gi < ASIN_STEPS; gi++) begin : g_step
      logic [ASIN_F_W-1:0] cand;
      logic cand_ok;
      logic [6:0] si;
      logic [CMP_W-1:0] lhs;
      logic [CMP_W-1:0] rhs;
      logic meets;
      logic [ASIN_F_W-1:0] acc_ff;
      logic [MAG_W-1:0] mag_ff;
      logic neg_ff;

      always_comb begin
         cand = acc_w[gi] | ASIN_F_W'(1 << (ASIN_STEPS - 1 - gi));
         cand_ok = (7'(cand) <= 7'(QUARTER_TURN_DEG - 1));
         si = cand_ok ? 7'(cand) : 7'd0;
         lhs = CMP_W'(mag_w[gi]) << SH_L;
         rhs = CMP_W'(SIN_TAB[si]) << SH_R;
         if (7'(cand) == 7'(ASIN_HALF_DEG)) begin
            meets = (CMP_W'(mag_w[gi]) << 1) >= LIM;
         end else begin
            meets = lhs >= rhs;
         end
      end

      always_ff @(posedge clock) begin
         acc_ff <= (cand_ok && meets) ? cand : acc_w[gi];
         mag_ff <= mag_w[gi];
         neg_ff <= neg_w[gi];
      end

      assign acc_w[gi+1] = acc_ff;
      assign mag_w[gi+1] = mag_ff;
      assign neg_w[gi+1] = neg_ff;
   end

   assign pad_w[0].deg = acc_w[ASIN_STEPS];
   assign pad_w[0].sat = CMP_W'(mag_w[ASIN_STEPS]) >= LIM;
   assign pad_w[0].neg = neg_w[ASIN_STEPS];

   for (genvar gp = 0; gp < PAD; gp++) begin : g_pad
      asin_out_type pad_ff;
      always_ff @(posedge clock) begin
         pad_ff <= pad_w[gp];
      end
      assign pad_w[gp+1] = pad_ff;
   end

   assign asin_out = pad_w[PAD];

endmodule

// ===== hdl/quaternion_to_euler_degrees_unit.sv =====
`timescale 1ns / 1ps
// Channel   Ports                                   Handshake
// request   req_quat_x/y/z/w                        start & !busy
// response  rsp_pitch_deg, rsp_yaw_deg, rsp_roll_deg  rsp_valid, one cycle
//
// One word enters every cycle; busy is always low.
// Pipeline: 3 front stages (products, sums, magnitude split), 12 stages for the six
// two-register atan compare steps, 1 output stage.
// Reset clears the valid chain only; words in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
module quaternion_to_euler_degrees_unit import qte_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic signed [15:0] req_quat_w,
   output logic              rsp_valid,
   output logic signed [8:0] rsp_pitch_deg,
   output logic signed [7:0] rsp_yaw_deg,
   output logic signed [8:0] rsp_roll_deg
);

   atan_in_type pitch_in, roll_in;
   asin_in_type yaw_in;
   atan_out_type pitch_out, roll_out;
   asin_out_type yaw_out;
   logic [TOTAL_LAT-1:0] valid_ff, valid_in;
   logic signed [8:0] pitch_ff, roll_ff, pitch_in_d, roll_in_d;
   logic signed [7:0] yaw_ff, yaw_in_d;

   function automatic logic signed [8:0] to_deg(atan_out_type a);
      logic [6:0] alpha;
      logic exact;
      logic [7:0] theta;
      priority if (a.side.y_zero) begin
         alpha = '0;
         exact = 1'b1;
      end else if (a.side.x_zero) begin
         alpha = 7'(QUARTER_TURN_DEG);
         exact = 1'b1;
      end else if (a.side.mag_eq) begin
         alpha = 7'(OCTANT_DEG);
         exact = 1'b1;
      end else begin
         exact = 1'b0;
         alpha = a.side.y_lt_x ? 7'(a.f) : 7'(QUARTER_TURN_DEG - 1) - 7'(a.f);
      end
      if (a.side.x_neg) begin
         theta = exact ? 8'(HALF_TURN_DEG) - 8'(alpha)
                       : 8'(HALF_TURN_DEG - 1) - 8'(alpha);
      end else begin
         theta = 8'(alpha);
      end
      return a.side.y_neg ? -$signed({1'b0, theta}) : $signed({1'b0, theta});
   endfunction

   qte_front u_front (
      .clock    (clock),
      .quat_x   (req_quat_x),
      .quat_y   (req_quat_y),
      .quat_z   (req_quat_z),
      .quat_w   (req_quat_w),
      .pitch_in (pitch_in),
      .roll_in  (roll_in),
      .yaw_in   (yaw_in)
   );

   qte_atan u_pitch (
      .clock    (clock),
      .atan_in  (pitch_in),
      .atan_out (pitch_out)
   );

   qte_atan u_roll (
      .clock    (clock),
      .atan_in  (roll_in),
      .atan_out (roll_out)
   );

   qte_asin u_yaw (
      .clock    (clock),
      .asin_in  (yaw_in),
      .asin_out (yaw_out)
   );

   always_comb begin
      valid_in = {valid_ff[TOTAL_LAT-2:0], start & ~busy};
      pitch_in_d = to_deg(pitch_out);
      roll_in_d = to_deg(roll_out);
      if (yaw_out.sat) begin
         yaw_in_d = yaw_out.neg ? -8'sd90 : 8'sd90;
      end else begin
         yaw_in_d = yaw_out.neg ? -$signed({1'b0, yaw_out.deg})
                                : $signed({1'b0, yaw_out.deg});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pitch_ff <= pitch_in_d;
      roll_ff <= roll_in_d;
      yaw_ff <= yaw_in_d;
   end

   assign busy = 1'b0;
   assign rsp_valid = valid_ff[TOTAL_LAT-1];
   assign rsp_pitch_deg = pitch_ff;
   assign rsp_yaw_deg = yaw_ff;
   assign rsp_roll_deg = roll_ff;

endmodule

// ===== hdl/qte_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module qte_checker import qte_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input logic signed [8:0] rsp_pitch_deg,
   input logic signed [7:0] rsp_yaw_deg,
   input logic signed [8:0] rsp_roll_deg
);

   `QTE_ASSERT_ALWAYS(a_never_busy, clock, reset, !busy)
   `QTE_ASSERT_NEXT(a_reset_flush, clock, reset, !rsp_valid)
   `QTE_ASSERT_IMPLY(a_word_origin, clock, reset, rsp_valid, $past(start, TOTAL_LAT))
   `QTE_ASSERT_IMPLY(a_yaw_range, clock, reset, rsp_valid, rsp_yaw_deg >= -8'sd90 && rsp_yaw_deg <= 8'sd90)
   `QTE_ASSERT_IMPLY(a_angle_range, clock, reset, rsp_valid, rsp_pitch_deg >= -9'sd180 && rsp_roll_deg >= -9'sd180)

endmodule

bind quaternion_to_euler_degrees_unit qte_checker u_qte_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_pitch_deg (rsp_pitch_deg),
   .rsp_yaw_deg   (rsp_yaw_deg),
   .rsp_roll_deg  (rsp_roll_deg)
);

// ===== tb/tb_quaternion_to_euler_degrees_unit.sv =====
`timescale 1ns / 1ps
module tb_quaternion_to_euler_degrees_unit;
   import qte_pkg::*;

   typedef struct {
      logic signed [8:0] pitch;
      logic signed [7:0] yaw;
      logic signed [8:0] roll;
   } euler_word_type;

   class euler_scoreboard;
      euler_word_type pending[$];
      bit [63:0] sin_deg[0:90];
      int errors;

      function new();
         bit [63:0] a, a2, t;
         longint s;
         errors = 0;
         for (int k = 0; k <= 90; k++) begin
            a = (64'(k) * PI_Q30 + 64'd90) / 64'd180;
            a2 = (a * a) >> 30;
            t = a;
            s = longint'(a);
            for (int n = 1; n <= 10; n++) begin
               t = ((t * a2) >> 30) / 64'((2 * n) * (2 * n + 1));
               s = (n % 2 == 1) ? s - longint'(t) : s + longint'(t);
            end
            sin_deg[k] = (s < 0) ? 64'd0 : 64'(s);
         end
      endfunction

      function bit [63:0] absval(longint v);
         return (v < 0) ? 64'(-v) : 64'(v);
      endfunction

      function int angle_of(longint num, longint den);
         bit [63:0] an, ad, lo, hi;
         int alpha, theta, f;
         bit exact;
         an = absval(num);
         ad = absval(den);
         exact = 1;
         if (an == 0) alpha = 0;
         else if (ad == 0) alpha = QUARTER_TURN_DEG;
         else if (an == ad) alpha = OCTANT_DEG;
         else begin
            lo = (an < ad) ? an : ad;
            hi = (an < ad) ? ad : an;
            f = 0;
            for (int k = 1; k < OCTANT_DEG; k++) begin
               if (lo * sin_deg[90 - k] >= hi * sin_deg[k]) f = k;
               else break;
            end
            exact = 0;
            alpha = (an < ad) ? f : QUARTER_TURN_DEG - 1 - f;
         end
         if (den < 0) theta = exact ? HALF_TURN_DEG - alpha : HALF_TURN_DEG - 1 - alpha;
         else theta = alpha;
         return (num < 0) ? -theta : theta;
      endfunction

      function int arcsine_of(longint v);
         bit [63:0] av, lim;
         int d;
         bit hit;
         av = absval(v);
         lim = 64'd1 << (2 * FRAC_BITS);
         d = 0;
         if (av >= lim) d = QUARTER_TURN_DEG;
         else begin
            for (int k = 1; k < QUARTER_TURN_DEG; k++) begin
               if (k == ASIN_HALF_DEG) hit = (2 * av >= lim);
               else if (2 * FRAC_BITS >= 30) hit = av >= (sin_deg[k] << (2 * FRAC_BITS - 30));
               else hit = (av << (30 - 2 * FRAC_BITS)) >= sin_deg[k];
               if (hit) d = k;
               else break;
            end
         end
         return (v < 0) ? -d : d;
      endfunction

      function void note_quat(logic signed [15:0] qx, logic signed [15:0] qy,
                              logic signed [15:0] qz, logic signed [15:0] qw);
         longint x, y, z, w;
         euler_word_type e;
         x = qx; y = qy; z = qz; w = qw;
         e.pitch = 9'(angle_of(2 * (y * z + w * x), w * w - x * x - y * y + z * z));
         e.yaw = 8'(arcsine_of(2 * (w * y - x * z)));
         e.roll = 9'(angle_of(2 * (x * y + w * z), w * w + x * x - y * y - z * z));
         pending.insert(pending.size(), e);
      endfunction

      function void check_angles(logic signed [8:0] p, logic signed [7:0] yw,
                                 logic signed [8:0] r);
         euler_word_type e;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected word p=%0d y=%0d r=%0d", p, yw, r);
            return;
         end
         e = pending.pop_front();
         if (e.pitch !== p || e.yaw !== yw || e.roll !== r) begin
            errors++;
            if (errors <= 10)
               $display("mismatch exp p=%0d y=%0d r=%0d got p=%0d y=%0d r=%0d",
                        e.pitch, e.yaw, e.roll, p, yw, r);
         end
      endfunction
   endclass

   logic clock, reset, start, busy, rsp_valid;
   logic signed [15:0] req_quat_x, req_quat_y, req_quat_z, req_quat_w;
   logic signed [8:0] rsp_pitch_deg, rsp_roll_deg;
   logic signed [7:0] rsp_yaw_deg;
   euler_scoreboard sb;

   quaternion_to_euler_degrees_unit u_top (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("quaternion_to_euler_degrees_unit regression: fail");
      $finish;
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note_quat(req_quat_x, req_quat_y, req_quat_z, req_quat_w);
         if (rsp_valid) sb.check_angles(rsp_pitch_deg, rsp_yaw_deg, rsp_roll_deg);
      end
   end

   task automatic send_quat(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                            logic [15:0] w, int gap);
      bit taken;
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_quat_x <= x; req_quat_y <= y; req_quat_z <= z; req_quat_w <= w;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (TOTAL_LAT + 8) @(posedge clock);
   endtask

   function automatic int draw_gap();
      return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
   endfunction

   task automatic send_unit_quat(int gap);
      real a, b, c, d, n;
      a = real'($urandom_range(0, 2000)) - 1000.0;
      b = real'($urandom_range(0, 2000)) - 1000.0;
      c = real'($urandom_range(0, 2000)) - 1000.0;
      d = real'($urandom_range(0, 2000)) - 1000.0;
      n = $sqrt(a * a + b * b + c * c + d * d);
      if (n == 0.0) begin
         a = 1.0; n = 1.0;
      end
      send_quat(16'($rtoi(16384.0 * a / n)), 16'($rtoi(16384.0 * b / n)),
                16'($rtoi(16384.0 * c / n)), 16'($rtoi(16384.0 * d / n)), gap);
   endtask

   initial begin
      sb = new();
      reset = 1; start = 0;
      req_quat_x = 0; req_quat_y = 0; req_quat_z = 0; req_quat_w = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_quat(0, 0, 0, 0, 0);
      send_quat(0, 0, 0, 16384, 0);
      send_quat(16384, 0, 0, 0, 0);
      send_quat(0, 16384, 0, 0, 1);
      send_quat(0, 0, 16384, 0, 0);
      send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
      send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 2);
      send_quat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 0);
      send_quat(0, 8192, 0, 8192, 0);
      send_quat(0, 16'(-8192), 0, 8192, 0);
      send_quat(8192, 0, 8192, 0, 3);
      send_quat(11585, 0, 0, 11585, 0);
      send_quat(0, 0, 11585, 11585, 0);
      send_quat(16'(-11585), 0, 0, 11585, 0);
      send_quat(0, 0, 16'(-11585), 11585, 0);
      send_quat(8192, 8192, 8192, 8192, 0);
      send_quat(16'(-8192), 8192, 16'(-8192), 8192, 1);
      send_quat(16384, 16384, 0, 0, 0);
      send_quat(0, 16384, 16384, 0, 0);
      send_quat(0, 0, 16'(-16384), 0, 0);
      send_quat(1, 0, 0, 16'hffff, 0);
      send_quat(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 0);
      drain();
      for (int i = 0; i < 650; i++) begin
         int g;
         g = (i / 80) % 2 == 1 ? 0 : draw_gap();
         if ($urandom_range(0, 9) < 6) send_unit_quat(g);
         else if ($urandom_range(0, 1) == 0)
            send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), g);
         else
            send_quat(16'($urandom_range(0, 64)) - 16'd32, 16'($urandom_range(0, 64)) - 16'd32,
                      16'($urandom_range(0, 64)) - 16'd32, 16'($urandom_range(0, 64)) - 16'd32, g);
         if (i == 300) drain();
      end
      drain();
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("quaternion_to_euler_degrees_unit regression: pass");
      else
         $display("quaternion_to_euler_degrees_unit regression: fail");
      $finish;
   end
endmodule
